@@ rtl/core/pidd_pkg.sv @@
// Shared types and constants for the pin interrupt dispatcher.
// Used by the controller, the datapath and the top level; no dependencies.
package pidd_pkg;

   localparam int PIN_COUNT_DEF    = 16;
   localparam int SETTLE_COUNT_DEF = 15;

   localparam logic [2:0] TYPE_OFF        = 3'd0;
   localparam logic [2:0] TYPE_HIGH_LEVEL = 3'd5;
   localparam logic [2:0] MODE_CLICK      = 3'd6;
   localparam logic [2:0] MODE_INVALID    = 3'd7;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_ACK   = 1'b1;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic       kind;
      logic [3:0] pin;
      logic       level;
      logic [2:0] armed_type;
   } result_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic arm_commit;
      logic scan_commit;
      logic flush_push;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_action;
      logic out_free;
      logic hold_valid;
      logic fire;
      logic last_pin;
   } status_type;

endpackage

@@ rtl/core/pidd_ctrl.sv @@
// Sequencer for the pin interrupt dispatcher: idle, arm, scan, flush.
// Depends on pidd_pkg for the command and status structs.
module pidd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pidd_pkg::status_type   status,
   output pidd_pkg::cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ARM   = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       stall;

   assign req_tready = (state_ff == ST_IDLE);
   // a second event cannot go while the held one has nowhere to go
   assign stall = status.fire && status.hold_valid && !status.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = status.req_action ? ST_ARM : ST_SCAN;
            end
         end
         ST_ARM: begin
            if (status.out_free) begin
               cmd.arm_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               cmd.scan_commit = 1'b1;
               if (status.last_pin) state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.hold_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush_push = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/core/pidd_datapath.sv @@
// Pin state, input capture, per-pin evaluation, held event and output register.
// Depends on pidd_pkg; driven by pidd_ctrl commands.
module pidd_datapath #(
   parameter int PIN_COUNT    = pidd_pkg::PIN_COUNT_DEF,
   parameter int SETTLE_COUNT = pidd_pkg::SETTLE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [39:0]           req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  pidd_pkg::cmd_type     cmd,
   output pidd_pkg::status_type  status
);

   localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

   // captured item
   logic [3:0]  pin_ff;
   logic [2:0]  mode_ff;
   logic [15:0] pending_ff;
   logic [15:0] levels_ff;

   // per-pin state
   logic [2:0] pin_type_ff [PIN_COUNT];
   logic [2:0] pin_type_in [PIN_COUNT];
   logic       click_ff    [PIN_COUNT];
   logic       click_in    [PIN_COUNT];
   logic [7:0] count_ff    [PIN_COUNT];
   logic [7:0] count_in    [PIN_COUNT];

   logic [IDX_W-1:0] scan_ff, scan_in;

   pidd_pkg::result_type hold_ff, hold_in;
   logic                 hold_valid_ff, hold_valid_in;
   pidd_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;

   // arm evaluation
   logic             arm_in_range;
   logic [IDX_W-1:0] arm_idx;
   logic             arm_level;
   logic [2:0]       arm_type;
   logic             arm_click;
   logic [7:0]       arm_count;

   // scan evaluation of the current pin
   logic [2:0] cur_type;
   logic       cur_click;
   logic [7:0] cur_count;
   logic       cur_level;
   logic       cur_active;
   logic       awaited;
   logic [7:0] moved_count;
   logic       fire;
   logic [2:0] new_type;
   logic [7:0] new_count;

   logic out_free;
   pidd_pkg::result_type ev;

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign arm_in_range = ({1'b0, pin_ff} < 5'(PIN_COUNT));
   assign arm_idx      = pin_ff[IDX_W-1:0];
   assign arm_level    = levels_ff[pin_ff];
   assign arm_click    = (mode_ff == pidd_pkg::MODE_CLICK);
   assign arm_count    = arm_click ? 8'(SETTLE_COUNT) : 8'd0;

   always_comb begin
      if (!arm_in_range)                         arm_type = pidd_pkg::TYPE_OFF;
      else if (arm_click)                        arm_type = pidd_pkg::TYPE_HIGH_LEVEL
                                                            - {2'b00, arm_level};
      else if (mode_ff == pidd_pkg::MODE_INVALID) arm_type = pidd_pkg::TYPE_OFF;
      else                                       arm_type = mode_ff;
   end

   assign cur_type   = pin_type_ff[scan_ff];
   assign cur_click  = click_ff[scan_ff];
   assign cur_count  = count_ff[scan_ff];
   assign cur_level  = levels_ff[scan_ff];
   assign cur_active = (cur_type != pidd_pkg::TYPE_OFF) && pending_ff[scan_ff];
   assign awaited    = (cur_type == pidd_pkg::TYPE_HIGH_LEVEL);

   // count down on the awaited level, up otherwise; both ends saturate
   always_comb begin
      if (cur_level == awaited)
         moved_count = (cur_count != 8'd0) ? cur_count - 8'd1 : 8'd0;
      else
         moved_count = (cur_count != pidd_pkg::COUNT_MAX) ? cur_count + 8'd1 : cur_count;
   end

   always_comb begin
      new_type  = cur_type;
      new_count = cur_count;
      fire      = 1'b0;
      if (cur_active) begin
         if (cur_click) begin
            new_count = moved_count;
            if (moved_count == 8'd0) begin
               fire      = 1'b1;
               new_type  = pidd_pkg::TYPE_HIGH_LEVEL - {2'b00, cur_level};
               new_count = 8'(SETTLE_COUNT);
            end
         end else begin
            fire = 1'b1;
         end
      end
   end

   always_comb begin
      ev.kind       = pidd_pkg::KIND_EVENT;
      ev.pin        = 4'(scan_ff);
      ev.level      = cur_level;
      ev.armed_type = new_type;
   end

   always_comb begin
      for (int i = 0; i < PIN_COUNT; i++) begin
         pin_type_in[i] = pin_type_ff[i];
         click_in[i]    = click_ff[i];
         count_in[i]    = count_ff[i];
      end
      if (cmd.arm_commit && arm_in_range) begin
         pin_type_in[arm_idx] = arm_type;
         click_in[arm_idx]    = arm_click;
         count_in[arm_idx]    = arm_count;
      end
      if (cmd.scan_commit) begin
         pin_type_in[scan_ff] = new_type;
         count_in[scan_ff]    = new_count;
      end
   end

   always_comb begin
      scan_in       = scan_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (cmd.capture) begin
         scan_in       = '0;
         hold_valid_in = 1'b0;
      end
      if (cmd.arm_commit) begin
         rsp_in.kind       = pidd_pkg::KIND_ACK;
         rsp_in.pin        = pin_ff;
         rsp_in.level      = arm_level;
         rsp_in.armed_type = arm_type;
         rsp_last_in       = 1'b1;
         rsp_valid_in      = 1'b1;
      end
      if (cmd.scan_commit) begin
         if (scan_ff != IDX_W'(PIN_COUNT - 1)) scan_in = scan_ff + IDX_W'(1);
         if (fire) begin
            if (hold_valid_ff) begin
               rsp_in       = hold_ff;
               rsp_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
            end
            hold_in       = ev;
            hold_valid_in = 1'b1;
         end
      end
      if (cmd.flush_push) begin
         rsp_in        = hold_ff;
         rsp_last_in   = 1'b1;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIN_COUNT; i++) begin
            pin_type_ff[i] <= pidd_pkg::TYPE_OFF;
            click_ff[i]    <= 1'b0;
            count_ff[i]    <= 8'd0;
         end
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_ff       <= '0;
      end else begin
         for (int i = 0; i < PIN_COUNT; i++) begin
            pin_type_ff[i] <= pin_type_in[i];
            click_ff[i]    <= click_in[i];
            count_ff[i]    <= count_in[i];
         end
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_ff       <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pin_ff     <= req_tdata[3:0];
         mode_ff    <= req_tdata[6:4];
         pending_ff <= req_tdata[22:7];
         levels_ff  <= req_tdata[38:23];
      end
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.req_action = req_tuser;
   assign status.out_free   = out_free;
   assign status.hold_valid = hold_valid_ff;
   assign status.fire       = fire;
   assign status.last_pin   = (scan_ff == IDX_W'(PIN_COUNT - 1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.armed_type, rsp_ff.level, rsp_ff.pin};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/core/pin_interrupt_dispatch_debounce.sv @@
// Top level of the pin interrupt dispatcher with click debounce.
// Instantiates pidd_ctrl and pidd_datapath; uses pidd_pkg.
//
//  channel | dir | tdata                                         | tuser   | tlast
//  req     | in  | pin[3:0] mode[6:4] pending[22:7] levels[38:23] | action  | -
//  rsp     | out | event_pin[3:0] event_level[4] armed_type[7:5]  | kind    | last
//
// Arm: capture, then commit into the output register once it is free.
// Dispatch: one pin evaluated per cycle by the scan counter unless the scan stalls,
// plus a flush of the held event; last is known only once the scan passes the end.
// A stalled rsp side holds the scan only when a second event finds both the held
// slot and the output register full. Reset clears all pin state.
module pin_interrupt_dispatch_debounce #(
   parameter int PIN_COUNT    = pidd_pkg::PIN_COUNT_DEF,
   parameter int SETTLE_COUNT = pidd_pkg::SETTLE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // pin, mode, pending, levels, zero pad
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // event_pin, event_level, armed_type
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast
);

   pidd_pkg::cmd_type    cmd;
   pidd_pkg::status_type status;

   pidd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pidd_datapath #(
      .PIN_COUNT    (PIN_COUNT),
      .SETTLE_COUNT (SETTLE_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
